// File: rtl/pirm_pkg.sv
// Shared types and constants for the PCM interpolating resampler and mixer.
// Used by the top level and the testbench; depends on nothing.
package pirm_pkg;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_FRAME  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int          RATE_W           = 17;
    localparam logic [16:0] OUTPUT_RATE_RST  = 17'd49716;
    localparam int          ADDR_W           = 3;
    localparam logic        REG_OUTPUT_RATE  = 1'b0;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         sample_byte;
        logic               restart_load;
        logic [15:0]        play_rate;
        logic               loop_enable;
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
    } in_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               playing;
    } out_t;

endpackage

// File: rtl/pcm_interp_resample_mixer_top.sv
// Sequence: loads and starts are taken in S_IDLE; an idle or stopping frame goes to
// S_DONE without a blend; a playing frame runs two divisions (blend and phase step), or
// four with a fraction carry and a wrap, on the shared bit-serial divider of DW =
// max(LEN_W + 20, 24) quotient bits.
// One item at a time: in_stall holds the next beat until the result is loaded for output.
// Reset clears length, phase and playback and loads output_rate with 49716, not memory.
module pcm_interp_resample_mixer_top #(
    parameter int MAX_SAMPLES = 16384
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pirm_pkg::in_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output pirm_pkg::out_t                out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pirm_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int LEN_W = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W = LEN_W + 20;
    localparam int DW    = (IDX_W > 24) ? IDX_W : 24;
    localparam int VW    = (LEN_W > 17) ? LEN_W : 17;

    typedef enum logic [3:0] {
        S_IDLE, S_CARRY, S_CHECK, S_WRAP, S_RDA, S_RDB,
        S_MULA, S_MULB, S_BLEND, S_STEP, S_DONE
    } state_t;

    state_t              state_reg;
    logic [16:0]         rate_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [16:0]         frac_reg;
    logic [15:0]         step_reg;
    logic                loop_reg;
    logic                active_reg;
    logic signed [15:0]  left_reg;
    logic signed [15:0]  right_reg;
    logic signed [8:0]   sa_reg;
    logic signed [8:0]   sb_reg;
    logic signed [26:0]  prod_reg;
    logic                neg_reg;
    logic                div_go_reg;
    logic                div_go_next;
    logic [DW-1:0]       div_a_reg;
    logic [VW-1:0]       div_b_reg;
    logic                out_valid_reg;
    pirm_pkg::out_t      out_data_reg;
    logic                play_reg;

    logic                accept;
    logic                cfg_wr;
    logic [16:0]         r_eff;
    logic [LEN_W-1:0]    len_ld;
    logic                mem_we;
    logic [AW-1:0]       mem_raddr;
    logic [7:0]          mem_rdata;
    logic [LEN_W:0]      idx_inc;
    logic [LEN_W-1:0]    nxt;
    logic                div_done;
    logic [DW-1:0]       div_q;
    logic [VW-1:0]       div_r;
    logic signed [27:0]  num;
    logic [27:0]         num_mag;
    logic signed [8:0]   blend;
    logic signed [16:0]  add_v;
    logic signed [16:0]  sum_l;
    logic signed [16:0]  sum_r;
    logic [17:0]         step_sum;
    logic                out_free;

    // handshakes
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == pirm_pkg::REG_OUTPUT_RATE) ? {15'd0, rate_reg} : 32'd0;
    assign r_eff    = (rate_reg == 17'd0) ? 17'd1 : rate_reg;
    assign out_free = !out_valid_reg || !out_stall;

    // load path: append at the (possibly restarted) length
    assign len_ld = in_data.restart_load ? '0 : len_reg;
    assign mem_we = accept && (in_data.kind == pirm_pkg::KIND_LOAD)
                    && (len_ld < LEN_W'(MAX_SAMPLES));

    // neighbour sample index; idx_reg is below len_reg here
    assign idx_inc = {1'b0, idx_reg[LEN_W-1:0]} + 1'b1;
    always_comb
    begin
        if (loop_reg)
        begin
            nxt = (idx_inc == {1'b0, len_reg}) ? '0 : idx_inc[LEN_W-1:0];
        end
        else
        begin
            nxt = (idx_inc < {1'b0, len_reg}) ? idx_inc[LEN_W-1:0] : len_reg - 1'b1;
        end
    end
    assign mem_raddr = (state_reg == S_RDA) ? AW'(idx_reg) : AW'(nxt);

    // blend numerator, its sign and magnitude
    assign num      = 28'(prod_reg) + 28'(sb_reg) * 28'($signed({1'b0, frac_reg}));
    assign num_mag  = num[27] ? 28'(-num) : 28'(num);
    assign blend    = neg_reg ? 9'(-$signed({1'b0, div_q[8:0]})) : $signed(div_q[8:0]);
    assign add_v    = {blend, 8'd0};
    assign sum_l    = 17'(left_reg) + add_v;
    assign sum_r    = 17'(right_reg) + add_v;
    assign step_sum = {1'b0, frac_reg} + {2'b0, step_reg};

    // start the divider for carry, wrap, blend and phase step
    always_comb
    begin
        div_go_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                div_go_next = accept && (in_data.kind == pirm_pkg::KIND_FRAME)
                              && active_reg && (frac_reg >= r_eff);
            end
            S_CHECK:
            begin
                div_go_next = (idx_reg >= IDX_W'(len_reg)) && loop_reg && (len_reg != '0);
            end
            S_MULB:
            begin
                div_go_next = 1'b1;
            end
            S_BLEND:
            begin
                div_go_next = div_done;
            end
            default:
            begin
                div_go_next = 1'b0;
            end
        endcase
    end

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        if (v > 17'sd32767)
        begin
            return 16'sh7fff;
        end
        else if (v < -17'sd32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    pirm_mem #(.DEPTH(MAX_SAMPLES), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(len_ld)),
        .wdata (in_data.sample_byte),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pirm_div #(.DW(DW), .VW(VW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    // sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rate_reg      <= pirm_pkg::OUTPUT_RATE_RST;
            len_reg       <= '0;
            idx_reg       <= '0;
            frac_reg      <= '0;
            step_reg      <= '0;
            loop_reg      <= 1'b0;
            active_reg    <= 1'b0;
            div_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_go_reg <= div_go_next;
            // raise the result beat when loaded, drop it once taken
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr && paddr[2] == pirm_pkg::REG_OUTPUT_RATE)
            begin
                rate_reg <= pwdata[16:0];
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_data.kind)
                            pirm_pkg::KIND_LOAD:
                            begin
                                len_reg <= mem_we ? len_ld + 1'b1 : len_ld;
                            end
                            pirm_pkg::KIND_START:
                            begin
                                idx_reg  <= '0;
                                frac_reg <= '0;
                                if (in_data.play_rate == 16'd0 || len_reg == '0)
                                begin
                                    step_reg   <= '0;
                                    loop_reg   <= 1'b0;
                                    active_reg <= 1'b0;
                                end
                                else
                                begin
                                    step_reg   <= in_data.play_rate;
                                    loop_reg   <= in_data.loop_enable;
                                    active_reg <= 1'b1;
                                end
                            end
                            pirm_pkg::KIND_FRAME:
                            begin
                                left_reg  <= in_data.left_in;
                                right_reg <= in_data.right_in;
                                play_reg  <= 1'b0;
                                if (!active_reg)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else if (frac_reg >= r_eff)
                                begin
                                    div_a_reg  <= DW'(frac_reg);
                                    div_b_reg  <= VW'(r_eff);
                                    state_reg  <= S_CARRY;
                                end
                                else
                                begin
                                    state_reg <= S_CHECK;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_CARRY:
                begin
                    if (div_done)
                    begin
                        idx_reg   <= idx_reg + IDX_W'(div_q);
                        frac_reg  <= div_r[16:0];
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (idx_reg >= IDX_W'(len_reg))
                    begin
                        if (!loop_reg || len_reg == '0)
                        begin
                            idx_reg    <= '0;
                            frac_reg   <= '0;
                            step_reg   <= '0;
                            loop_reg   <= 1'b0;
                            active_reg <= 1'b0;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            div_a_reg  <= DW'(idx_reg);
                            div_b_reg  <= VW'(len_reg);
                            state_reg  <= S_WRAP;
                        end
                    end
                    else
                    begin
                        state_reg <= S_RDA;
                    end
                end
                S_WRAP:
                begin
                    if (div_done)
                    begin
                        idx_reg   <= IDX_W'(div_r);
                        state_reg <= S_RDA;
                    end
                end
                S_RDA:
                begin
                    state_reg <= S_RDB;
                end
                S_RDB:
                begin
                    sa_reg    <= $signed({1'b0, mem_rdata}) - 9'sd128;
                    state_reg <= S_MULA;
                end
                S_MULA:
                begin
                    sb_reg    <= $signed({1'b0, mem_rdata}) - 9'sd128;
                    prod_reg  <= sa_reg * $signed({1'b0, r_eff - frac_reg});
                    state_reg <= S_MULB;
                end
                S_MULB:
                begin
                    neg_reg    <= num[27];
                    div_a_reg  <= DW'(num_mag[23:0]);
                    div_b_reg  <= VW'(r_eff);
                    state_reg  <= S_BLEND;
                end
                S_BLEND:
                begin
                    if (div_done)
                    begin
                        left_reg   <= sat16(sum_l);
                        right_reg  <= sat16(sum_r);
                        div_a_reg  <= DW'(step_sum);
                        div_b_reg  <= VW'(r_eff);
                        state_reg  <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    if (div_done)
                    begin
                        idx_reg   <= idx_reg + IDX_W'(div_q);
                        frac_reg  <= div_r[16:0];
                        play_reg  <= 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_data_reg.left_out  <= left_reg;
                        out_data_reg.right_out <= right_reg;
                        out_data_reg.playing   <= play_reg;
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    // playback is only ever armed with a rate and a stored effect
    a_active_armed: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (step_reg != 16'd0 && len_reg != '0))
        else $error("active without rate or length");

    // reads stay inside the stored effect
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDA) |-> (idx_reg < IDX_W'(len_reg)))
        else $error("sample read beyond stored length");

    // a division finishes only while the sequencer waits for one
    a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_CARRY || state_reg == S_WRAP ||
                      state_reg == S_BLEND || state_reg == S_STEP))
        else $error("unexpected divider completion");
`endif

endmodule

// File: rtl/pirm_div.sv
// Restoring divider, one quotient bit per cycle while busy, shared by all divisions.
// Depends on nothing; started by a one-cycle go pulse.
module pirm_div #(
    parameter int DW = 24,
    parameter int VW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quot,
    output logic [VW-1:0] rem
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quot_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic [VW:0]   diff;

    // shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, quot_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !go && (cnt_reg == CW'(DW - 1));
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quot_reg <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                if (!diff[VW])
                begin
                    rem_reg  <= diff[VW-1:0];
                    quot_reg <= {quot_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= trial[VW-1:0];
                    quot_reg <= {quot_reg[DW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/pirm_mem.sv
// Effect sample memory: one write port, one read port, registered read data.
// Depends on nothing.
module pirm_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // write the appended byte
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: dv/tb_pcm_interp_resample_mixer_top.sv
// Self-checking testbench for the PCM interpolating resampler and mixer top level.
// Depends on pirm_pkg and pcm_interp_resample_mixer_top; carries its own predictor.
`timescale 1ns / 100ps

module tb_pcm_interp_resample_mixer_top;

    localparam int STORE_DEPTH = 32;
    localparam int QUIET_LIMIT = 6000;
    localparam int HOLD_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    pirm_pkg::in_t  in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    pirm_pkg::out_t out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [pirm_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [7:0]       smp_mem [STORE_DEPTH];
    int unsigned      smp_len = 0;
    int unsigned      ph_idx = 0;
    longint unsigned  ph_frac = 0;
    longint unsigned  ph_step = 0;
    bit               ph_loop = 0;
    bit               fx_active = 0;
    logic [16:0]      cfg_rate = pirm_pkg::OUTPUT_RATE_RST;

    pirm_pkg::out_t frames_due [$];
    int   err_cnt = 0;
    int   n_items = 0;
    int   n_frames = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_start = 0;
    int   hold_left = 0;
    int   quiet = 0;

    pcm_interp_resample_mixer_top #(.MAX_SAMPLES(STORE_DEPTH)) uut (.*);

    always #2 clk = ~clk;

    function automatic int sat16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Random bits for every field of a beat
    function automatic pirm_pkg::in_t rand_beat();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(pirm_pkg::in_t)-1:0];
    endfunction

    // Advance the predictor by one beat; returns 1 when a frame comes out
    function automatic bit mix_predict(input pirm_pkg::in_t d, output pirm_pkg::out_t res);
        longint unsigned rr, sum;
        longint signed   a, b, blend;
        int              lft, rgt, add;
        int unsigned     nxt;
        rr = (cfg_rate == 0) ? 1 : cfg_rate;
        res = '0;
        case (d.kind)
            pirm_pkg::KIND_LOAD:
            begin
                if (d.restart_load) smp_len = 0;
                if (smp_len < STORE_DEPTH)
                begin
                    smp_mem[smp_len] = d.sample_byte;
                    smp_len++;
                end
                return 0;
            end
            pirm_pkg::KIND_START:
            begin
                ph_idx = 0;
                ph_frac = 0;
                ph_step = d.play_rate;
                ph_loop = d.loop_enable;
                fx_active = 1;
                if (ph_step == 0 || smp_len == 0)
                begin
                    ph_step = 0;
                    ph_loop = 0;
                    fx_active = 0;
                end
                return 0;
            end
            pirm_pkg::KIND_FRAME:
            begin
                lft = d.left_in;
                rgt = d.right_in;
                if (fx_active)
                begin
                    // carry a fraction left over from a larger rate
                    if (ph_frac >= rr)
                    begin
                        ph_idx += int'(ph_frac / rr);
                        ph_frac = ph_frac % rr;
                    end
                    if (ph_idx >= smp_len)
                    begin
                        if (!ph_loop || smp_len == 0)
                        begin
                            ph_idx = 0;
                            ph_frac = 0;
                            ph_step = 0;
                            ph_loop = 0;
                            fx_active = 0;
                        end
                        else
                            ph_idx = ph_idx % smp_len;
                    end
                end
                if (fx_active)
                begin
                    if (ph_loop)
                        nxt = (ph_idx + 1) % smp_len;
                    else
                        nxt = (ph_idx + 1 < smp_len) ? ph_idx + 1 : smp_len - 1;
                    a = longint'(smp_mem[ph_idx]) - 128;
                    b = longint'(smp_mem[nxt]) - 128;
                    blend = (a * longint'(rr - ph_frac) + b * longint'(ph_frac)) / longint'(rr);
                    add = int'(blend * 256);
                    lft = sat16(lft + add);
                    rgt = sat16(rgt + add);
                    sum = ph_frac + ph_step;
                    ph_idx += int'(sum / rr);
                    ph_frac = sum % rr;
                end
                res.left_out = lft[15:0];
                res.right_out = rgt[15:0];
                res.playing = fx_active;
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    // Offer one beat, hold it until taken, then predict
    task automatic send_beat(input pirm_pkg::in_t d);
        pirm_pkg::out_t res;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (d.kind != pirm_pkg::KIND_UNUSED) n_items++;
        if (mix_predict(d, res)) frames_due.push_back(res);
    endtask

    task automatic send_load(input logic [7:0] v, input bit restart);
        pirm_pkg::in_t d;
        d = rand_beat();
        d.kind = pirm_pkg::KIND_LOAD;
        d.sample_byte = v;
        d.restart_load = restart;
        send_beat(d);
    endtask

    task automatic send_start(input logic [15:0] rate, input bit lp);
        pirm_pkg::in_t d;
        d = rand_beat();
        d.kind = pirm_pkg::KIND_START;
        d.play_rate = rate;
        d.loop_enable = lp;
        send_beat(d);
    endtask

    task automatic send_frame(input logic [15:0] l, input logic [15:0] r);
        pirm_pkg::in_t d;
        d = rand_beat();
        d.kind = pirm_pkg::KIND_FRAME;
        d.left_in = l;
        d.right_in = r;
        send_beat(d);
    endtask

    task automatic send_frame_rand();
        send_frame(16'($urandom), 16'($urandom));
    endtask

    // Drop valid and wait until every frame has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Write output_rate and read it back
    task automatic set_output_rate(input logic [16:0] v);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= pirm_pkg::ADDR_W'(pirm_pkg::REG_OUTPUT_RATE) << 2;
        pwdata <= {15'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        cfg_rate = v;
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== {15'd0, v})
        begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("output_rate readback: exp %0d got %0d", v, prdata);
        end
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    // Receiver: random stall, or a long hold when asked
    always @(negedge clk)
    begin
        if (hold_start)
        begin
            hold_left = HOLD_CYCLES;
            hold_start = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Check each returned frame against the oldest prediction
    always @(posedge clk)
    begin
        pirm_pkg::out_t want;
        if (out_valid && !out_stall)
        begin
            n_frames++;
            if (frames_due.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected frame: l %0d r %0d p %0b",
                             out_data.left_out, out_data.right_out, out_data.playing);
            end
            else
            begin
                want = frames_due.pop_front();
                if (out_data.left_out !== want.left_out ||
                    out_data.right_out !== want.right_out ||
                    out_data.playing !== want.playing)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("frame mismatch: exp l %0d r %0d p %0b, got l %0d r %0d p %0b",
                                 want.left_out, want.right_out, want.playing,
                                 out_data.left_out, out_data.right_out, out_data.playing);
                end
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", quiet);
            $display("tb_pcm_interp_resample_mixer_top: FAIL");
            $finish;
        end
    end

    // Idle frames, ignored kind, rejected starts, saturation and the end of a one-shot
    task automatic test_directed();
        pirm_pkg::in_t d;
        send_frame(16'sh7FFF, 16'sh8000);
        d = rand_beat();
        d.kind = pirm_pkg::KIND_UNUSED;
        send_beat(d);
        send_start(16'hFFFF, 1'b1);
        send_frame(16'h0000, 16'hFFFF);
        send_load(8'h00, 1'b1);
        send_load(8'hFF, 1'b0);
        send_load(8'h80, 1'b0);
        send_load(8'h7F, 1'b0);
        send_start(16'h0000, 1'b1);
        send_frame(16'h1234, 16'h8765);
        send_start(16'(49716), 1'b0);
        send_frame(16'sh8000, 16'sh8000);
        send_frame(16'sh7FFF, 16'sh7FFF);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh0000, 16'sh0000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_start(16'hFFFF, 1'b1);
        send_frame(16'sh7FFF, 16'sh8000);
        send_load(8'hC3, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF);
        send_start(16'd1, 1'b0);
        send_frame(16'sh4000, 16'shC000);
        send_frame(16'sh7FFF, 16'sh8000);
        drain();
    endtask

    // Overfill the store, then play it from its start, looped and then one-shot
    task automatic test_store_full();
        send_load(8'($urandom), 1'b1);
        for (int i = 0; i < STORE_DEPTH + 2; i++) send_load(8'($urandom), 1'b0);
        send_start(16'hFFFF, 1'b1);
        repeat (4) send_frame_rand();
        send_start(16'hFFFF, 1'b0);
        repeat (3) send_frame_rand();
        drain();
    endtask

    // Hold the receiver off while frames keep coming
    task automatic test_backpressure();
        send_load(8'($urandom), 1'b1);
        repeat (7) send_load(8'($urandom), 1'b0);
        send_start(16'd20000, 1'b1);
        hold_start = 1;
        repeat (24) send_frame_rand();
        drain();
    endtask

    // Mostly load, start, play sequences; some noise and broken sequences
    task automatic test_random(input int n);
        int start_n;
        int nb;
        pirm_pkg::in_t d;
        start_n = n_items;
        while (n_items - start_n < n)
        begin
            if ($urandom_range(99) < 85)
            begin
                if ($urandom_range(3) != 0)
                begin
                    nb = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 24);
                    send_load(8'($urandom), 1'b1);
                    for (int i = 1; i < nb; i++) send_load(8'($urandom), 1'b0);
                end
                case ($urandom_range(3))
                    0: send_start(16'($urandom_range(1, 255)), 1'($urandom));
                    1: send_start(16'((cfg_rate >> $urandom_range(0, 4)) | 1), 1'($urandom));
                    2: send_start(16'hFFFF, 1'($urandom));
                    default: send_start(16'($urandom), 1'($urandom));
                endcase
                nb = $urandom_range(2, 12);
                for (int i = 0; i < nb; i++)
                begin
                    if ($urandom_range(19) == 0)
                        send_load(8'($urandom), $urandom_range(3) == 0);
                    send_frame_rand();
                end
            end
            else
            begin
                d = rand_beat();
                if (d.kind == pirm_pkg::KIND_START && $urandom_range(1)) d.play_rate = 0;
                send_beat(d);
            end
        end
        drain();
    endtask

    // Random phases under each idling scheme and several output rates
    task automatic test_rates_and_idling();
        logic [16:0] rates [6];
        rates = '{17'd0, 17'd131071, 17'd1, 17'd44100, 17'd49716, 17'd0};
        rates[5] = 17'($urandom_range(2, 131070));
        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 67 : 0;
            recv_idle_pct = (ph < 2) ? 67 : (ph < 4) ? 34 : 0;
            set_output_rate(rates[ph]);
            test_random(50);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 34;
        recv_idle_pct = 67;
        test_directed();
        test_store_full();
        test_backpressure();
        test_rates_and_idling();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_output_rate(pirm_pkg::OUTPUT_RATE_RST);
        repeat (200) @(posedge clk);
        $display("covered %0d items and %0d mixed frames: loads, starts, loops, one-shots,",
                 n_items, n_frames);
        $display("a full store, output_rate extremes and a long receiver hold");
        if (err_cnt == 0 && frames_due.size() == 0)
            $display("tb_pcm_interp_resample_mixer_top: PASS");
        else
            $display("tb_pcm_interp_resample_mixer_top: FAIL");
        $finish;
    end

endmodule
